/* rtl/core/zszm_pkg.sv */
// ----------------------------------------------------------------------------
// zszm_pkg
// Shared constants and types for the zone manager core.
// ----------------------------------------------------------------------------
package zszm_pkg;

  localparam int NUM_ZONES = 256;
  localparam int ZIW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int CW = 9;

  typedef enum logic [2:0] {
    ZC_EMPTY   = 3'd0,
    ZC_IOPEN   = 3'd1,
    ZC_EOPEN   = 3'd2,
    ZC_CLOSED  = 3'd3,
    ZC_RONLY   = 3'd4,
    ZC_FULL    = 3'd5,
    ZC_OFFLINE = 3'd6,
    ZC_UNUSED  = 3'd7
  } zcond_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TRANS = 3'd1,
    ST_NO_ACTIVE = 3'd2,
    ST_NO_OPEN   = 3'd3,
    ST_NO_ZRWA   = 3'd4,
    ST_BAD_ZOP   = 3'd5,
    ST_BAD_FIELD = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FN_CLOSE   = 3'd0,
    FN_FINISH  = 3'd1,
    FN_OPEN    = 3'd2,
    FN_RESET   = 3'd3,
    FN_OFFLINE = 3'd4,
    FN_FLUSH   = 3'd5
  } func_t;

  localparam logic [2:0] REG_MAX_ACTIVE = 3'd0;
  localparam logic [2:0] REG_MAX_OPEN   = 3'd1;
  localparam logic [2:0] REG_MAX_ZRWA   = 3'd2;
  localparam logic [2:0] REG_ZSIZE_LOG2 = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;
  localparam logic [2:0] REG_WINDOW     = 3'd5;
  localparam logic [2:0] REG_GRANULE    = 3'd6;

endpackage

/* rtl/core/zoned_storage_zone_manager_core.sv */
// ----------------------------------------------------------------------------
// zoned_storage_zone_manager_core
// Zone management send: per-zone state machine with resource accounting.
// ----------------------------------------------------------------------------
// Request channel: func, start_lba, zrwa_option, all_zones with
// in_valid/in_ready. Response channel: status with out_valid/out_ready.
// Configuration: cfg_we, cfg_index, cfg_data; the user must write them
// while idle, which the core itself does not enforce. A single-zone
// request passes from accept to response valid through zone memory read,
// read register, check, write back and response. The flush granule check,
// run on a flush that passes the range checks, uses a shared restoring
// remainder unit, one quotient bit per cycle. A select-all request walks
// every zone through the same read/check/write sequence, and through the
// remainder unit each zone that reaches it. A request is taken only in
// the idle state, once the previous one has reached its response. After
// reset the zone tables are cleared by a pass over all NUM_ZONES zones,
// one zone per cycle, during which no request is taken; limits return to
// their reset values. A finished response is held in an output register;
// the core accepts the next request while it waits, but finishes that
// request only after the previous response has been taken.
// ----------------------------------------------------------------------------
module zoned_storage_zone_manager_core
  import zszm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] start_lba,
  input  logic        zrwa_option,
  input  logic        all_zones,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CHECK, S_DIV, S_WRITE, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] max_active, max_open, max_zrwa;
  logic [4:0]    zs_log2;
  logic [24:0]   capacity;
  logic [16:0]   window, granule;

  logic [CW-1:0] active_count, open_count, zrwa_count;

  logic [2:0]  cond_mem [NUM_ZONES];
  logic [24:0] wp_mem   [NUM_ZONES];
  logic        zv_mem   [NUM_ZONES];

  logic [2:0]  rd_cond;
  logic [24:0] rd_wp;
  logic        rd_zv;

  logic [2:0]   r_func;
  logic         r_zopt, r_all;
  logic [ZIW-1:0] zone;
  logic [ZIW:0] zcnt;
  logic [24:0]  r_off;
  logic         r_off_hi;
  logic [2:0]   r_status;

  logic         we;
  logic [2:0]   w_cond;
  logic [24:0]  w_wp;
  logic         w_zv;

  logic [17:0] rem;
  logic [16:0] dvd;
  logic [4:0]  dcnt;

  // Zone index and offset
  logic [63:0] lba_ext;
  logic [63:0] zi_full;
  logic [31:0] off_mask;
  logic [31:0] off_full;
  logic        zone_oor;
  assign lba_ext  = {32'd0, start_lba};
  assign zi_full  = lba_ext >> zs_log2;
  assign off_mask = (zs_log2 > 5'd31) ? 32'hFFFF_FFFF : ((32'd1 << zs_log2) - 32'd1);
  assign off_full = start_lba & off_mask;
  assign zone_oor = zi_full >= 64'(NUM_ZONES);

  logic [24:0] ucap;
  assign ucap = (zs_log2 > 5'd24) ? capacity :
                ((capacity > (25'd1 << zs_log2)) ? (25'd1 << zs_log2) : capacity);

  logic [16:0] gran_eff;
  assign gran_eff = (granule == 17'd0) ? 17'd1 : granule;

  function automatic logic [CW-1:0] dn(input logic [CW-1:0] c);
    return (c != '0) ? c - 1'b1 : c;
  endfunction

  assign in_ready = (state == S_IDLE);

  // Check stage
  logic [2:0]  n_status;
  logic [2:0]  n_cond;
  logic [24:0] n_wp;
  logic        n_zv, n_we, n_div;
  logic [CW-1:0] n_act, n_opn, n_zrw;
  logic        c_open;
  logic [25:0] dlt;
  logic        flush_range_ok;

  assign c_open = (rd_cond == ZC_IOPEN) || (rd_cond == ZC_EOPEN);
  assign dlt = {1'b0, r_off} - {1'b0, rd_wp};
  assign flush_range_ok = rd_zv && !r_off_hi && (r_off >= rd_wp) &&
                          (dlt < {9'd0, window}) && (r_off < ucap);

  always_comb begin
    n_status = ST_BAD_TRANS;
    n_cond = rd_cond;
    n_wp = rd_wp;
    n_zv = rd_zv;
    n_we = 1'b0;
    n_div = 1'b0;
    n_act = active_count;
    n_opn = open_count;
    n_zrw = zrwa_count;
    unique case (r_func)
      FN_CLOSE: begin
        if (c_open) begin
          n_cond = ZC_CLOSED; n_opn = dn(open_count); n_we = 1'b1; n_status = ST_OK;
        end else if (rd_cond == ZC_CLOSED) begin
          n_status = ST_OK;
        end
      end
      FN_FINISH: begin
        if (c_open || rd_cond == ZC_CLOSED) begin
          if (c_open) n_opn = dn(open_count);
          n_act = dn(active_count);
          if (rd_zv) n_zrw = dn(zrwa_count);
          n_zv = 1'b0; n_cond = ZC_FULL; n_we = 1'b1; n_status = ST_OK;
        end else if (rd_cond == ZC_EMPTY) begin
          n_cond = ZC_FULL; n_we = 1'b1; n_status = ST_OK;
        end else if (rd_cond == ZC_FULL) begin
          n_status = ST_OK;
        end
      end
      FN_OPEN: begin
        if (rd_cond == ZC_EMPTY) begin
          if (active_count >= max_active) n_status = ST_NO_ACTIVE;
          else if (open_count >= max_open) n_status = ST_NO_OPEN;
          else if (r_zopt && zrwa_count >= max_zrwa) n_status = ST_NO_ZRWA;
          else begin
            if (r_zopt) begin
              n_zrw = zrwa_count + 1'b1; n_zv = 1'b1;
            end
            n_act = active_count + 1'b1;
            n_opn = open_count + 1'b1;
            n_cond = ZC_EOPEN; n_we = 1'b1; n_status = ST_OK;
          end
        end else if (rd_cond == ZC_CLOSED) begin
          if (open_count >= max_open) n_status = ST_NO_OPEN;
          else begin
            n_opn = open_count + 1'b1; n_cond = ZC_EOPEN; n_we = 1'b1; n_status = ST_OK;
          end
        end else if (rd_cond == ZC_IOPEN) begin
          n_cond = ZC_EOPEN; n_we = 1'b1; n_status = ST_OK;
        end else if (rd_cond == ZC_EOPEN) begin
          n_status = ST_OK;
        end
      end
      FN_RESET: begin
        if (c_open || rd_cond == ZC_CLOSED || rd_cond == ZC_FULL ||
            rd_cond == ZC_EMPTY) begin
          if (c_open || rd_cond == ZC_CLOSED) begin
            if (c_open) n_opn = dn(open_count);
            n_act = dn(active_count);
            if (rd_zv) n_zrw = dn(zrwa_count);
          end
          n_cond = ZC_EMPTY; n_wp = '0; n_zv = 1'b0; n_we = 1'b1; n_status = ST_OK;
        end
      end
      FN_OFFLINE: begin
        if (rd_cond == ZC_RONLY) begin
          n_cond = ZC_OFFLINE; n_we = 1'b1; n_status = ST_OK;
        end else if (rd_cond == ZC_OFFLINE) begin
          n_status = ST_OK;
        end
      end
      default: begin
        if (!flush_range_ok) n_status = ST_BAD_ZOP;
        else n_div = 1'b1;
      end
    endcase
  end

  // Flush completion after granule check
  logic [24:0] f_wp1;
  logic        f_full, f_okcond;
  assign f_wp1 = r_off + 25'd1;
  assign f_full = ({1'b0, r_off} + 26'd1) == {1'b0, ucap};
  assign f_okcond = c_open || (rd_cond == ZC_CLOSED);

  logic [17:0] rem_sh;
  assign rem_sh = {rem[16:0], dvd[16]};

  always_ff @(posedge clk) begin
    if (we) begin
      cond_mem[zone] <= w_cond;
      wp_mem[zone]   <= w_wp;
      zv_mem[zone]   <= w_zv;
    end
    rd_cond <= cond_mem[zone];
    rd_wp   <= wp_mem[zone];
    rd_zv   <= zv_mem[zone];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      zcnt <= '0;
      zone <= '0;
      we <= 1'b1;
      w_cond <= ZC_EMPTY; w_wp <= '0; w_zv <= 1'b0;
      out_valid <= 1'b0;
      active_count <= '0; open_count <= '0; zrwa_count <= '0;
      max_active <= 9'd256; max_open <= 9'd256; max_zrwa <= 9'd16;
      zs_log2 <= 5'd16; capacity <= 25'd65536; window <= 17'd64; granule <= 17'd8;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_ACTIVE: max_active <= cfg_data[8:0];
          REG_MAX_OPEN:   max_open   <= cfg_data[8:0];
          REG_MAX_ZRWA:   max_zrwa   <= cfg_data[8:0];
          REG_ZSIZE_LOG2: zs_log2    <= cfg_data[4:0];
          REG_CAPACITY:   capacity   <= cfg_data;
          REG_WINDOW:     window     <= cfg_data[16:0];
          REG_GRANULE:    granule    <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (zcnt == (ZIW+1)'(NUM_ZONES - 1) || NUM_ZONES == 1) begin
            we <= 1'b0; zone <= '0; state <= S_IDLE;
          end else begin
            zone <= zone + 1'b1; zcnt <= zcnt + 1'b1;
          end
        end
        S_IDLE: begin
          we <= 1'b0;
          if (in_valid && in_ready) begin
            r_func <= func; r_zopt <= zrwa_option; r_all <= all_zones;
            if (func > FN_FLUSH) begin
              r_status <= ST_BAD_FIELD; state <= S_DONE;
            end else if (all_zones) begin
              zone <= '0; zcnt <= '0; r_off <= '0; r_off_hi <= 1'b0;
              r_status <= ST_OK; state <= S_READ;
            end else if (zone_oor) begin
              r_status <= ST_BAD_FIELD; state <= S_DONE;
            end else begin
              zone <= zi_full[ZIW-1:0];
              r_off <= off_full[24:0];
              r_off_hi <= |off_full[31:25];
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_CHECK;
        S_CHECK: begin
          if (n_div) begin
            rem <= '0; dvd <= dlt[16:0] + 17'd1; dcnt <= '0; state <= S_DIV;
          end else begin
            if (!r_all) r_status <= n_status;
            we <= n_we; w_cond <= n_cond; w_wp <= n_wp; w_zv <= n_zv;
            active_count <= n_act; open_count <= n_opn; zrwa_count <= n_zrw;
            state <= S_WRITE;
          end
        end
        S_DIV: begin
          rem <= (rem_sh >= {1'b0, gran_eff}) ? rem_sh - {1'b0, gran_eff} : rem_sh;
          dvd <= {dvd[15:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'd17) begin
            if (rem != '0) begin
              if (!r_all) r_status <= ST_BAD_FIELD;
            end else if (!f_okcond) begin
              if (!r_all) r_status <= ST_BAD_ZOP;
            end else begin
              if (!r_all) r_status <= ST_OK;
              we <= 1'b1; w_wp <= f_wp1; w_cond <= rd_cond; w_zv <= rd_zv;
              if (f_full) begin
                if (rd_cond != ZC_CLOSED) open_count <= dn(open_count);
                active_count <= dn(active_count);
                zrwa_count <= dn(zrwa_count);
                w_zv <= 1'b0; w_cond <= ZC_FULL;
              end
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          we <= 1'b0;
          if (r_all && zcnt != (ZIW+1)'(NUM_ZONES - 1) && NUM_ZONES != 1) begin
            zone <= zone + 1'b1; zcnt <= zcnt + 1'b1; state <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1; status <= r_status; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/zszm_checker.sv */
// ----------------------------------------------------------------------------
// zszm_checker
// Port-level checks on the zone manager core.
// ----------------------------------------------------------------------------
module zszm_checker
  import zszm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("response dropped or changed under stall");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_FIELD)
    else $error("status out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind zoned_storage_zone_manager_core zszm_checker u_zszm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status)
);
